>>> hdl/bskv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bskv_pkg
// Shared constants, codes and controller/datapath types of the byte store
// key/value engine.
// ----------------------------------------------------------------------------
package bskv_pkg;

    localparam int StoreBytes = 1024;
    localparam int AddrW      = $clog2(StoreBytes);
    localparam int MaxField   = 32;
    localparam int LenW       = 6;
    localparam int NeedW      = 7;
    localparam int WordW      = 64;

    localparam logic [7:0] MarkEmpty = 8'hFF;
    localparam logic [7:0] MarkRec   = 8'h0C;
    localparam logic [7:0] MarkVal   = 8'hAA;
    localparam logic [7:0] MarkEnd   = 8'hEE;

    localparam logic [1:0] ReqRead   = 2'd0;
    localparam logic [1:0] ReqWrite  = 2'd1;
    localparam logic [1:0] ReqForget = 2'd2;
    localparam logic [1:0] ReqBad    = 2'd3;

    localparam logic [2:0] StOk       = 3'd0;
    localparam logic [2:0] StEmpty    = 3'd1;
    localparam logic [2:0] StExists   = 3'd2;
    localparam logic [2:0] StNoSpace  = 3'd3;
    localparam logic [2:0] StNotFound = 3'd4;
    localparam logic [2:0] StBadInput = 3'd5;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHECK,
        S_FK_RD,
        S_FK_EV,
        S_RV_RD,
        S_RV_EV,
        S_FS_RD,
        S_FS_EV,
        S_WR,
        S_FG_RD,
        S_FG_EV,
        S_DONE
    } state_t;

    typedef struct packed {
        logic       load;
        logic       addr_clr;
        logic       addr_inc;
        logic       fk_step;
        logic       fs_step;
        logic       rv_step;
        logic       addr_rec;
        logic       wr_start;
        logic       wr_ff;
        logic       wr_rec;
        logic       set_st;
        logic [2:0] st;
        logic       finish;
    } cmd_t;

    typedef struct packed {
        logic       bad;
        logic [1:0] req;
        logic       match;
        logic       last;
        logic       past_end;
        logic       flen_full;
        logic       b_end;
        logic       run_hit;
        logic       wr_last;
        logic       out_busy;
    } stat_t;

endpackage
`default_nettype wire

>>> hdl/bskv_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bskv_req_if / bskv_rsp_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface bskv_req_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      req_type;
    logic [bskv_pkg::WordW-1:0]      key_w0;
    logic [bskv_pkg::WordW-1:0]      key_w1;
    logic [bskv_pkg::WordW-1:0]      key_w2;
    logic [bskv_pkg::WordW-1:0]      key_w3;
    logic [bskv_pkg::LenW-1:0]       key_len;
    logic [bskv_pkg::WordW-1:0]      val_w0;
    logic [bskv_pkg::WordW-1:0]      val_w1;
    logic [bskv_pkg::WordW-1:0]      val_w2;
    logic [bskv_pkg::WordW-1:0]      val_w3;
    logic [bskv_pkg::LenW-1:0]       val_len;

    modport source (output valid, req_type, key_w0, key_w1, key_w2, key_w3, key_len,
                    val_w0, val_w1, val_w2, val_w3, val_len, input ready);
    modport sink (input valid, req_type, key_w0, key_w1, key_w2, key_w3, key_len,
                  val_w0, val_w1, val_w2, val_w3, val_len, output ready);
endinterface

interface bskv_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [2:0]                      status;
    logic [bskv_pkg::WordW-1:0]      found_w0;
    logic [bskv_pkg::WordW-1:0]      found_w1;
    logic [bskv_pkg::WordW-1:0]      found_w2;
    logic [bskv_pkg::WordW-1:0]      found_w3;
    logic [bskv_pkg::LenW-1:0]       found_len;
    logic [bskv_pkg::AddrW-1:0]      record_addr;

    modport source (output valid, status, found_w0, found_w1, found_w2, found_w3,
                    found_len, record_addr, input ready);
    modport sink (input valid, status, found_w0, found_w1, found_w2, found_w3,
                  found_len, record_addr, output ready);
endinterface
`default_nettype wire

>>> hdl/bskv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bskv_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bskv_ram #(
    parameter int Width = 8,
    parameter int Depth = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic      [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule
`default_nettype wire

>>> hdl/bskv_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bskv_dp
// Datapath: request registers, byte store, scan registers and result register.
// ----------------------------------------------------------------------------
module bskv_dp (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire bskv_pkg::cmd_t  cmd,
    output bskv_pkg::stat_t      stat,
    bskv_req_if.sink             request,
    bskv_rsp_if.source           response
);

    localparam int AW = bskv_pkg::AddrW;

    logic [1:0]                    req_reg;
    logic [31:0][7:0]              key_reg;
    logic [31:0][7:0]              val_reg;
    logic [bskv_pkg::LenW-1:0]     klen_reg;
    logic [bskv_pkg::LenW-1:0]     vlen_reg;
    logic [AW:0]                   addr_reg, addr_next;
    logic                          in_rec_reg, in_rec_next;
    logic                          eq_reg, eq_next;
    logic [bskv_pkg::LenW-1:0]     j_reg, j_next;
    logic [AW-1:0]                 rec_reg, rec_next;
    logic [bskv_pkg::NeedW-1:0]    run_reg, run_next;
    logic [bskv_pkg::NeedW-1:0]    wk_reg, wk_next;
    logic [31:0][7:0]              found_reg;
    logic [bskv_pkg::LenW-1:0]     flen_reg;
    logic [AW-1:0]                 raddr_reg;
    logic [2:0]                    st_reg;
    logic                          out_valid_reg, out_valid_next;
    logic [255:0]                  out_found_reg;
    logic [bskv_pkg::LenW-1:0]     out_flen_reg;
    logic [AW-1:0]                 out_raddr_reg;
    logic [2:0]                    out_st_reg;

    logic [7:0]                    rd;
    logic [7:0]                    wdata;
    logic [7:0]                    rec_byte;
    logic                          we;
    logic [bskv_pkg::NeedW-1:0]    need;
    logic [bskv_pkg::NeedW-1:0]    kl7;
    logic [bskv_pkg::NeedW-1:0]    vidx;
    logic [bskv_pkg::NeedW-1:0]    kidx;
    logic [AW:0]                   start;

    bskv_ram #(
        .Width (8),
        .Depth (bskv_pkg::StoreBytes)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr_reg[AW-1:0]),
        .wdata (wdata),
        .rdata (rd)
    );

    assign kl7   = {1'b0, klen_reg};
    assign need  = kl7 + {1'b0, vlen_reg} + bskv_pkg::NeedW'(3);
    assign kidx  = wk_reg - bskv_pkg::NeedW'(1);
    assign vidx  = wk_reg - kl7 - bskv_pkg::NeedW'(2);
    assign start = addr_reg - {{(AW+1-bskv_pkg::NeedW){1'b0}}, need} + (AW+1)'(1);

    // record layout: marker, key, separator, value, end mark
    always_comb
    begin
        if (wk_reg == '0)
        begin
            rec_byte = bskv_pkg::MarkRec;
        end
        else if (wk_reg <= kl7)
        begin
            rec_byte = key_reg[kidx[4:0]];
        end
        else if (wk_reg == kl7 + bskv_pkg::NeedW'(1))
        begin
            rec_byte = bskv_pkg::MarkVal;
        end
        else if (wk_reg == need - bskv_pkg::NeedW'(1))
        begin
            rec_byte = bskv_pkg::MarkEnd;
        end
        else
        begin
            rec_byte = val_reg[vidx[4:0]];
        end
    end

    assign we    = cmd.wr_ff | cmd.wr_rec;
    assign wdata = cmd.wr_rec ? rec_byte : bskv_pkg::MarkEmpty;

    always_comb
    begin
        stat.req       = req_reg;
        stat.bad       = (req_reg == bskv_pkg::ReqBad)
                       || (klen_reg == '0) || (klen_reg > bskv_pkg::LenW'(bskv_pkg::MaxField))
                       || ((req_reg == bskv_pkg::ReqWrite)
                           && ((vlen_reg == '0)
                               || (vlen_reg > bskv_pkg::LenW'(bskv_pkg::MaxField))));
        stat.match     = in_rec_reg && (rd == bskv_pkg::MarkVal) && eq_reg && (j_reg == klen_reg);
        stat.last      = addr_reg == (AW+1)'(bskv_pkg::StoreBytes - 1);
        stat.past_end  = addr_reg[AW];
        stat.flen_full = flen_reg == bskv_pkg::LenW'(bskv_pkg::MaxField);
        stat.b_end     = rd == bskv_pkg::MarkEnd;
        stat.run_hit   = (rd == bskv_pkg::MarkEmpty) && (run_reg + bskv_pkg::NeedW'(1) == need);
        stat.wr_last   = wk_reg == need - bskv_pkg::NeedW'(1);
        stat.out_busy  = out_valid_reg && !response.ready;
    end

    always_comb
    begin
        addr_next   = addr_reg;
        in_rec_next = in_rec_reg;
        eq_next     = eq_reg;
        j_next      = j_reg;
        rec_next    = rec_reg;
        run_next    = run_reg;
        wk_next     = wk_reg;
        if (cmd.addr_clr)
        begin
            addr_next   = '0;
            in_rec_next = 1'b0;
            run_next    = '0;
        end
        else if (cmd.addr_inc)
        begin
            addr_next = addr_reg + (AW+1)'(1);
        end
        else if (cmd.addr_rec)
        begin
            addr_next = {1'b0, rec_reg};
        end
        else if (cmd.wr_start)
        begin
            addr_next = start;
            wk_next   = '0;
        end
        if (cmd.wr_rec)
        begin
            wk_next = wk_reg + bskv_pkg::NeedW'(1);
        end
        // key scan: marker, then key bytes up to the separator
        if (cmd.fk_step)
        begin
            if (!in_rec_reg)
            begin
                if (rd == bskv_pkg::MarkRec)
                begin
                    in_rec_next = 1'b1;
                    j_next      = '0;
                    eq_next     = 1'b1;
                    rec_next    = addr_reg[AW-1:0];
                end
            end
            else if (rd == bskv_pkg::MarkVal)
            begin
                in_rec_next = 1'b0;
            end
            else if (j_reg >= bskv_pkg::LenW'(bskv_pkg::MaxField))
            begin
                in_rec_next = 1'b0;
            end
            else
            begin
                if ((j_reg >= klen_reg) || (key_reg[j_reg[4:0]] != rd))
                begin
                    eq_next = 1'b0;
                end
                j_next = j_reg + bskv_pkg::LenW'(1);
            end
        end
        if (cmd.fs_step)
        begin
            run_next = (rd == bskv_pkg::MarkEmpty) ? run_reg + bskv_pkg::NeedW'(1) : '0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (response.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            in_rec_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            addr_reg      <= addr_next;
            in_rec_reg    <= in_rec_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eq_reg  <= eq_next;
        j_reg   <= j_next;
        rec_reg <= rec_next;
        run_reg <= run_next;
        wk_reg  <= wk_next;
        if (cmd.load)
        begin
            req_reg   <= request.req_type;
            key_reg   <= {request.key_w3, request.key_w2, request.key_w1, request.key_w0};
            val_reg   <= {request.val_w3, request.val_w2, request.val_w1, request.val_w0};
            klen_reg  <= request.key_len;
            vlen_reg  <= request.val_len;
            found_reg <= '0;
            flen_reg  <= '0;
            raddr_reg <= '0;
            st_reg    <= bskv_pkg::StOk;
        end
        if (cmd.rv_step)
        begin
            found_reg[flen_reg[4:0]] <= rd;
            flen_reg                 <= flen_reg + bskv_pkg::LenW'(1);
        end
        if (cmd.wr_start)
        begin
            raddr_reg <= start[AW-1:0];
        end
        if (cmd.set_st)
        begin
            st_reg <= cmd.st;
        end
        if (cmd.finish)
        begin
            out_found_reg <= found_reg;
            out_flen_reg  <= flen_reg;
            out_raddr_reg <= raddr_reg;
            out_st_reg    <= st_reg;
        end
    end

    assign response.valid       = out_valid_reg;
    assign response.status      = out_st_reg;
    assign response.found_w0    = out_found_reg[63:0];
    assign response.found_w1    = out_found_reg[127:64];
    assign response.found_w2    = out_found_reg[191:128];
    assign response.found_w3    = out_found_reg[255:192];
    assign response.found_len   = out_flen_reg;
    assign response.record_addr = out_raddr_reg;

endmodule
`default_nettype wire

>>> hdl/bskv_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bskv_ctrl
// Sequencer: store clearing, key scan, value read, free-space search,
// record write and forget.
// ----------------------------------------------------------------------------
module bskv_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire bskv_pkg::stat_t stat,
    output bskv_pkg::cmd_t       cmd
);

    bskv_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bskv_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            bskv_pkg::S_CLEAR:
            begin
                cmd.wr_ff    = 1'b1;
                cmd.addr_inc = 1'b1;
                if (stat.last)
                begin
                    state_next = bskv_pkg::S_IDLE;
                end
            end
            bskv_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bskv_pkg::S_CHECK;
                end
            end
            bskv_pkg::S_CHECK:
            begin
                cmd.addr_clr = 1'b1;
                if (stat.bad)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = bskv_pkg::StBadInput;
                    state_next = bskv_pkg::S_DONE;
                end
                else
                begin
                    state_next = bskv_pkg::S_FK_RD;
                end
            end
            bskv_pkg::S_FK_RD:
            begin
                state_next = bskv_pkg::S_FK_EV;
            end
            bskv_pkg::S_FK_EV:
            begin
                if (stat.match)
                begin
                    case (stat.req)
                        bskv_pkg::ReqRead:
                        begin
                            cmd.addr_inc = 1'b1;
                            state_next   = bskv_pkg::S_RV_RD;
                        end
                        bskv_pkg::ReqWrite:
                        begin
                            cmd.set_st = 1'b1;
                            cmd.st     = bskv_pkg::StExists;
                            state_next = bskv_pkg::S_DONE;
                        end
                        default:
                        begin
                            cmd.addr_rec = 1'b1;
                            state_next   = bskv_pkg::S_FG_RD;
                        end
                    endcase
                end
                else
                begin
                    cmd.fk_step  = 1'b1;
                    cmd.addr_inc = 1'b1;
                    state_next   = bskv_pkg::S_FK_RD;
                    if (stat.last)
                    begin
                        case (stat.req)
                            bskv_pkg::ReqRead:
                            begin
                                cmd.set_st = 1'b1;
                                cmd.st     = bskv_pkg::StEmpty;
                                state_next = bskv_pkg::S_DONE;
                            end
                            bskv_pkg::ReqWrite:
                            begin
                                cmd.addr_inc = 1'b0;
                                cmd.addr_clr = 1'b1;
                                state_next   = bskv_pkg::S_FS_RD;
                            end
                            default:
                            begin
                                cmd.set_st = 1'b1;
                                cmd.st     = bskv_pkg::StNotFound;
                                state_next = bskv_pkg::S_DONE;
                            end
                        endcase
                    end
                end
            end
            bskv_pkg::S_RV_RD:
            begin
                if (stat.past_end || stat.flen_full)
                begin
                    state_next = bskv_pkg::S_DONE;
                end
                else
                begin
                    state_next = bskv_pkg::S_RV_EV;
                end
            end
            bskv_pkg::S_RV_EV:
            begin
                if (stat.b_end)
                begin
                    state_next = bskv_pkg::S_DONE;
                end
                else
                begin
                    cmd.rv_step  = 1'b1;
                    cmd.addr_inc = 1'b1;
                    state_next   = bskv_pkg::S_RV_RD;
                end
            end
            bskv_pkg::S_FS_RD:
            begin
                state_next = bskv_pkg::S_FS_EV;
            end
            bskv_pkg::S_FS_EV:
            begin
                if (stat.run_hit)
                begin
                    cmd.wr_start = 1'b1;
                    state_next   = bskv_pkg::S_WR;
                end
                else if (stat.last)
                begin
                    cmd.set_st = 1'b1;
                    cmd.st     = bskv_pkg::StNoSpace;
                    state_next = bskv_pkg::S_DONE;
                end
                else
                begin
                    cmd.fs_step  = 1'b1;
                    cmd.addr_inc = 1'b1;
                    state_next   = bskv_pkg::S_FS_RD;
                end
            end
            bskv_pkg::S_WR:
            begin
                cmd.wr_rec   = 1'b1;
                cmd.addr_inc = 1'b1;
                if (stat.wr_last)
                begin
                    state_next = bskv_pkg::S_DONE;
                end
            end
            bskv_pkg::S_FG_RD:
            begin
                state_next = bskv_pkg::S_FG_EV;
            end
            bskv_pkg::S_FG_EV:
            begin
                // erase the byte just read, stop after the end mark or the last store byte
                cmd.wr_ff = 1'b1;
                if (stat.b_end || stat.last)
                begin
                    state_next = bskv_pkg::S_DONE;
                end
                else
                begin
                    cmd.addr_inc = 1'b1;
                    state_next   = bskv_pkg::S_FG_RD;
                end
            end
            bskv_pkg::S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = bskv_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bskv_pkg::S_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

>>> hdl/byte_store_key_value_engine_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// byte_store_key_value_engine_top
// Key/value records kept in a 1024-byte erased store; read, write, forget.
// ----------------------------------------------------------------------------
//   channel    dir   handshake      payload
//   request    in    valid/ready    req_type, key_w0..3, key_len, val_w0..3, val_len
//   response   out   valid/ready    status, found_w0..3, found_len, record_addr
//
// after reset the store is swept to 0xFF with request.ready low
// each store byte a scan visits takes a read state and an evaluate state
// (single-port ram, registered read); a write that finds no match adds a
// free-space scan and then writes a record of key+value+3 bytes
// one request at a time; a finished result waits in an output register
// while the next request is taken
// ----------------------------------------------------------------------------
module byte_store_key_value_engine_top (
    input  wire logic   clk,
    input  wire logic   rst_n,
    bskv_req_if.sink    request,
    bskv_rsp_if.source  response
);

    bskv_pkg::cmd_t  cmd;
    bskv_pkg::stat_t stat;

    bskv_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bskv_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .stat     (stat),
        .request  (request),
        .response (response)
    );

endmodule
`default_nettype wire
